/* rtl/core/assert_macros.svh */
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/hpq_pkg.sv */
package hpq_pkg;

   localparam int unsigned DefCapacity = 1024;
   localparam int unsigned KeyWidth    = 32;
   localparam int unsigned CountWidth  = 11;

   // request kind carried in tuser
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // result status carried in tuser
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   // command broadcast along the cell row
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

/* rtl/core/hpq_cell.sv */
module hpq_cell (
   input  logic                               clock,
   input  hpq_pkg::cell_ctl_type              ctl,
   input  logic signed [hpq_pkg::KeyWidth-1:0] value,
   input  logic                               valid,
   input  logic signed [hpq_pkg::KeyWidth-1:0] prev_data,
   input  logic                               prev_gt,
   input  logic signed [hpq_pkg::KeyWidth-1:0] next_data,
   output logic signed [hpq_pkg::KeyWidth-1:0] data,
   output logic                               gt
);

   logic signed [hpq_pkg::KeyWidth-1:0] data_ff;
   logic signed [hpq_pkg::KeyWidth-1:0] data_in;

   // new key beats this entry, or the slot is empty
   assign gt = !valid || (value > data_ff);

   // sorted row: push shifts down from the insertion point, pop shifts up
   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         if (prev_gt) begin
            data_in = prev_data;
         end else if (gt) begin
            data_in = value;
         end
      end else if (ctl.pop) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/max_heap_priority_queue_core.sv */
// the result of a transferred request is registered in the output register
// throughput: one item per cycle while results are taken; a request is taken
// whenever the output register is empty or being drained
// every row cell compares and shifts in parallel
// reset: synchronous, clears the entry count and the output valid; keys are not cleared
module max_heap_priority_queue_core #(
   parameter int unsigned CAPACITY = hpq_pkg::DefCapacity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // popped_value, top_value, entry_count, zero pad
   output logic [1:0]  rsp_tuser    // status
);

   `include "assert_macros.svh"

   localparam int unsigned CntW = $clog2(CAPACITY + 1);
   localparam int unsigned KW   = hpq_pkg::KeyWidth;

   logic                 accept;
   logic [CntW-1:0]      count_ff, count_in;
   hpq_pkg::cell_ctl_type ctl;
   logic signed [KW-1:0] value;
   logic                 do_push, do_pop, is_full, is_empty;
   hpq_pkg::status_type  status;

   logic signed [KW-1:0] cell_data [CAPACITY];
   logic                 cell_gt   [CAPACITY];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [KW-1:0] popped_ff, popped_in, top_ff, top_in;
   logic [CntW-1:0]      rsp_count_ff;
   hpq_pkg::status_type  status_ff;
   logic [CntW+hpq_pkg::CountWidth-1:0] count_wide;

   assign accept   = req_tvalid && req_tready;
   assign value    = req_tdata;
   assign is_full  = (count_ff == CntW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign do_push  = accept && (req_tuser == hpq_pkg::OP_PUSH) && !is_full;
   assign do_pop   = accept && (req_tuser == hpq_pkg::OP_POP) && !is_empty;
   assign ctl.push = do_push;
   assign ctl.pop  = do_pop;

   // row of sorted cells, largest key in cell zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KW-1:0] prev_d, next_d;
      logic                 prev_g, vld;
      if (i == 0) begin : g_first
         assign prev_d = '0;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_d = cell_data[i-1];
         assign prev_g = cell_gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_inner
         assign next_d = cell_data[i+1];
      end
      assign vld = (CntW'(i) < count_ff);
      hpq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .value     (value),
         .valid     (vld),
         .prev_data (prev_d),
         .prev_gt   (prev_g),
         .next_data (next_d),
         .data      (cell_data[i]),
         .gt        (cell_gt[i])
      );
   end

   // count and result for the accepted request
   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      top_in    = is_empty ? '0 : cell_data[0];
      status    = hpq_pkg::STATUS_OK;
      if (accept && (req_tuser == hpq_pkg::OP_PUSH)) begin
         if (is_full) begin
            status = hpq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
            top_in   = cell_gt[0] ? value : cell_data[0];
         end
      end else if (accept) begin
         if (is_empty) begin
            status = hpq_pkg::STATUS_EMPTY;
         end else begin
            count_in  = count_ff - 1'b1;
            popped_in = cell_data[0];
            top_in    = (count_ff > CntW'(1)) ? cell_data[1] : '0;
         end
      end
   end

   // output register
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         top_ff       <= top_in;
         rsp_count_ff <= count_in;
         status_ff    <= status;
      end
   end

   assign count_wide = {{hpq_pkg::CountWidth{1'b0}}, rsp_count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, count_wide[hpq_pkg::CountWidth-1:0], top_ff, popped_ff};
   assign rsp_tuser  = status_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(CAPACITY))
   `ASSERT_NEXT(a_empty_pop, clock, reset,
      accept && (req_tuser == hpq_pkg::OP_POP) && is_empty,
      status_ff == hpq_pkg::STATUS_EMPTY && count_ff == '0)
   `ASSERT_NEXT(a_pop_max, clock, reset, do_pop,
      popped_ff == $past(cell_data[0]) && count_ff == $past(count_ff) - 1'b1)
   `ASSERT_NEXT(a_full_push, clock, reset,
      accept && (req_tuser == hpq_pkg::OP_PUSH) && is_full,
      status_ff == hpq_pkg::STATUS_FULL && $stable(count_ff))

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HeapDepth  = hpq_pkg::DefCapacity;
   localparam int unsigned IdleLimit  = 5000;
   localparam int unsigned StallLen   = 400;
   localparam int unsigned MixLen     = 100;
   localparam int unsigned TailLen    = 40;

   typedef struct packed {
      logic [31:0]         popped;
      logic [31:0]         top;
      logic [10:0]         count;
      hpq_pkg::status_type status;
   } heap_result_type;

   typedef struct {
      hpq_pkg::op_type op;
      logic [31:0]     value;
      bit              typed;
      heap_result_type result;
   } heap_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   max_heap_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow heap and pending results
   logic [31:0]     shadow_heap [HeapDepth];
   int unsigned     shadow_fill;
   heap_result_type pending_results [$];
   heap_row_type    directed_rows [$];
   int unsigned     error_count;
   int unsigned     result_count;
   int unsigned     idle_cycles;
   bit              sender_done;
   bit              burst_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h expected %h (result %0d)", field, got, want,
               result_count);
      error_count++;
   endtask

   // one heap operation on the shadow copy, returns the result it causes
   function automatic heap_result_type heap_apply(input hpq_pkg::op_type op,
                                                  input logic [31:0] value);
      heap_result_type res;
      int unsigned     pos;
      int unsigned     parent;
      int unsigned     left;
      int unsigned     right;
      int unsigned     pick;
      logic [31:0]     tmp;
      res = '0;
      res.status = hpq_pkg::STATUS_OK;
      if (op == hpq_pkg::OP_PUSH) begin
         if (shadow_fill >= HeapDepth) begin
            res.status = hpq_pkg::STATUS_FULL;
         end else begin
            // append and sift up while strictly larger than the parent
            pos = shadow_fill;
            shadow_heap[pos] = value;
            shadow_fill++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if ($signed(shadow_heap[pos]) > $signed(shadow_heap[parent])) begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[parent];
                  shadow_heap[parent] = tmp;
                  pos = parent;
               end else begin
                  break;
               end
            end
         end
      end else begin
         if (shadow_fill == 0) begin
            res.status = hpq_pkg::STATUS_EMPTY;
         end else begin
            // take the root, move the last entry up and sift it down
            res.popped = shadow_heap[0];
            shadow_fill--;
            shadow_heap[0] = shadow_heap[shadow_fill];
            pos = 0;
            forever begin
               left = 2 * pos + 1;
               right = left + 1;
               if (left >= shadow_fill) break;
               pick = left;
               if (right < shadow_fill &&
                   !($signed(shadow_heap[left]) > $signed(shadow_heap[right])))
                  pick = right;
               if ($signed(shadow_heap[pick]) > $signed(shadow_heap[pos])) begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[pick];
                  shadow_heap[pick] = tmp;
                  pos = pick;
               end else begin
                  break;
               end
            end
         end
      end
      res.top = (shadow_fill > 0) ? shadow_heap[0] : 32'd0;
      res.count = shadow_fill[10:0];
      return res;
   endfunction

   function automatic logic [31:0] draw_key();
      case ($urandom_range(0, 3))
         0: return 32'($signed($urandom_range(0, 7)) - 4);
         1: return ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic add_row(input hpq_pkg::op_type op, input logic [31:0] value,
                          input bit typed, input logic [31:0] popped,
                          input logic [31:0] top, input logic [10:0] count,
                          input hpq_pkg::status_type status);
      heap_row_type row;
      row.op = op;
      row.value = value;
      row.typed = typed;
      row.result = '{popped: popped, top: top, count: count, status: status};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // offer one item and wait for its transfer, then log the expectation
   task automatic send_item(input hpq_pkg::op_type op, input logic [31:0] value,
                            input bit typed, input heap_result_type typed_res);
      heap_result_type res;
      int unsigned     gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = heap_apply(op, value);
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      heap_result_type none;
      int unsigned     k;
      hpq_pkg::op_type op;
      none = '0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= hpq_pkg::OP_PUSH;
      shadow_fill = 0;
      error_count = 0;
      sender_done = 0;
      burst_mode = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty, extremes, last entry, equal keys
      add_row(hpq_pkg::OP_POP,  32'h1234_5678, 1, 32'd0, 32'd0, 11'd0,
              hpq_pkg::STATUS_EMPTY);
      add_row(hpq_pkg::OP_PUSH, 32'h7fff_ffff, 1, 32'd0, 32'h7fff_ffff, 11'd1,
              hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'h8000_0000, 1, 32'd0, 32'h7fff_ffff, 11'd2,
              hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_POP,  32'hffff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000, 11'd1,
              hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_POP,  32'd0, 1, 32'h8000_0000, 32'd0, 11'd0,
              hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_POP,  32'd0, 1, 32'd0, 32'd0, 11'd0, hpq_pkg::STATUS_EMPTY);
      add_row(hpq_pkg::OP_PUSH, 32'd0, 1, 32'd0, 32'd0, 11'd1, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'd5, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'd5, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'hffff_ffff, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'd5, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'd3, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'd3, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'h8000_0000, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      add_row(hpq_pkg::OP_PUSH, 32'h7fff_ffff, 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      for (k = 0; k < 10; k++)
         add_row(hpq_pkg::OP_POP, 32'($urandom), 0, 0, 0, 0, hpq_pkg::STATUS_OK);
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].result);

      // sender pause until every result is back
      drain_wait();

      // push-leaning mix
      for (k = 0; k < MixLen; k++) begin
         if (k % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         op = ($urandom_range(0, 9) < 7) ? hpq_pkg::OP_PUSH : hpq_pkg::OP_POP;
         send_item(op, draw_key(), 0, none);
      end

      // fill up to capacity, then a few rejected pushes
      k = 0;
      while (shadow_fill < HeapDepth || k < 6) begin
         if (shadow_fill >= HeapDepth) k++;
         if ($urandom_range(0, 63) == 0) burst_mode = ~burst_mode;
         send_item(hpq_pkg::OP_PUSH, draw_key(), 0, none);
      end

      // balanced mix near full, with pushes and pops interleaved
      for (k = 0; k < TailLen; k++) begin
         if (k % 40 == 0) burst_mode = ($urandom_range(0, 1) == 0);
         op = ($urandom_range(0, 1) == 1) ? hpq_pkg::OP_PUSH : hpq_pkg::OP_POP;
         send_item(op, draw_key(), 0, none);
      end

      req_tvalid <= 1'b0;
      sender_done = 1;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS max_heap_priority_queue_core");
      end else begin
         $display("FAIL max_heap_priority_queue_core");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off, field checks
   initial begin
      heap_result_type want;
      heap_result_type got;
      int unsigned     gap;
      bit              stalled;
      rsp_tready <= 1'b0;
      result_count = 0;
      stalled = 0;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (!stalled && result_count == 300) begin
            stalled = 1;
            gap = StallLen;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.popped = rsp_tdata[31:0];
         got.top = rsp_tdata[63:32];
         got.count = rsp_tdata[74:64];
         got.status = hpq_pkg::status_type'(rsp_tuser);
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(result_count), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (got.popped !== want.popped) report_mismatch("popped_value", got.popped,
                                                            want.popped);
            if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
            if (got.count !== want.count) report_mismatch("entry_count", 32'(got.count),
                                                          32'(want.count));
            if (got.status !== want.status) report_mismatch("status", 32'(got.status),
                                                            32'(want.status));
            if (rsp_tdata[79:75] !== 5'd0) report_mismatch("pad", 32'(rsp_tdata[79:75]),
                                                           32'd0);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAIL max_heap_priority_queue_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
